// ===== hdl/mrw_pkg.sv =====
// ----------------------------------------------------------------------------
// mrw_pkg
// Shared types for the Miller-Rabin witness test: I/O words and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package mrw_pkg;

    typedef struct packed {
        logic [63:0] candidate;
        logic [63:0] witness;
        logic        last_witness;
    } t_in_word;

    typedef struct packed {
        logic verdict;
        logic final_res;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPLIT,
        S_RED_GO,
        S_RED_WT,
        S_POW_CHK,
        S_POWR_GO,
        S_POWR_WT,
        S_POWS_GO,
        S_POWS_WT,
        S_TEST,
        S_SQ_GO,
        S_SQ_WT,
        S_SQ_CHK,
        S_DONE
    } t_state;

endpackage

// ===== hdl/miller_rabin_witness_test.sv =====
// ----------------------------------------------------------------------------
// miller_rabin_witness_test
// One Miller-Rabin round per input word; a sticky flag ANDs the rounds of
// one candidate until the word marked as its last witness.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | word
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_word)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (t_out_word)
//
//  Every modular multiply goes through one bit-serial unit.
//  Trivial candidates (below 2, even, or 2) go straight to the result; for
//  others the run time is set by the number of multiplies: reduce, up to
//  two per bit of the odd part s, r-1 squarings (bits of s plus r never
//  exceed WIDTH).
//  o_in_ready is high only while the sequencer idles; the output register
//  lets the next word start while a result waits. Synchronous reset clears
//  the sequencer, the output valid and sets the sticky pass flag.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test #(
    parameter int WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mrw_pkg::t_in_word i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mrw_pkg::t_out_word o_out_data
);

    localparam int RW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    mrw_pkg::t_state r_state, n_state;

    logic [WIDTH-1:0] r_n;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_nm1;
    logic [WIDTH-1:0] r_s;
    logic [WIDTH-1:0] r_sq;
    logic [WIDTH-1:0] r_res;
    logic [RW-1:0]    r_r;
    logic             r_last;
    logic             r_pass;
    logic             r_all_passed;
    logic             r_out_valid;
    mrw_pkg::t_out_word r_out_data;

    logic [WIDTH-1:0] cand;
    logic             accept;
    logic             trivial;
    logic             is_two;
    logic             res_is_one;
    logic             res_is_nm1;
    logic             out_free;
    logic             verdict;

    logic             mm_start;
    logic [WIDTH-1:0] mm_x;
    logic [WIDTH-1:0] mm_y;
    logic             mm_done;
    logic [WIDTH-1:0] mm_prod;

    assign cand       = i_in_data.candidate[WIDTH-1:0];
    assign accept     = i_in_valid && o_in_ready;
    assign is_two     = (cand == WIDTH'(2));
    assign trivial    = (cand < WIDTH'(2)) || is_two || !cand[0];
    assign res_is_one = (r_res == WIDTH'(1));
    assign res_is_nm1 = (r_res == r_nm1);
    assign out_free   = !r_out_valid || i_out_ready;
    assign verdict    = r_all_passed && r_pass;

    mrw_modmul #(
        .WIDTH(WIDTH)
    ) u_modmul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mm_start),
        .i_x    (mm_x),
        .i_y    (mm_y),
        .i_n    (r_n),
        .o_done (mm_done),
        .o_prod (mm_prod)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mrw_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = trivial ? mrw_pkg::S_DONE : mrw_pkg::S_SPLIT;
                end
            end
            mrw_pkg::S_SPLIT: begin
                if (r_s[0]) n_state = mrw_pkg::S_RED_GO;
            end
            mrw_pkg::S_RED_GO:  n_state = mrw_pkg::S_RED_WT;
            mrw_pkg::S_RED_WT: begin
                if (mm_done) n_state = mrw_pkg::S_POW_CHK;
            end
            mrw_pkg::S_POW_CHK: begin
                if (r_s == '0) begin
                    n_state = mrw_pkg::S_TEST;
                end else if (r_s[0]) begin
                    n_state = mrw_pkg::S_POWR_GO;
                end else begin
                    n_state = mrw_pkg::S_POWS_GO;
                end
            end
            mrw_pkg::S_POWR_GO: n_state = mrw_pkg::S_POWR_WT;
            mrw_pkg::S_POWR_WT: begin
                if (mm_done) n_state = mrw_pkg::S_POWS_GO;
            end
            mrw_pkg::S_POWS_GO: n_state = mrw_pkg::S_POWS_WT;
            mrw_pkg::S_POWS_WT: begin
                if (mm_done) n_state = mrw_pkg::S_POW_CHK;
            end
            mrw_pkg::S_TEST: begin
                if (res_is_one || res_is_nm1 || r_r == RW'(1)) begin
                    n_state = mrw_pkg::S_DONE;
                end else begin
                    n_state = mrw_pkg::S_SQ_GO;
                end
            end
            mrw_pkg::S_SQ_GO:   n_state = mrw_pkg::S_SQ_WT;
            mrw_pkg::S_SQ_WT: begin
                if (mm_done) n_state = mrw_pkg::S_SQ_CHK;
            end
            mrw_pkg::S_SQ_CHK: begin
                if (res_is_one || res_is_nm1 || r_r == RW'(1)) begin
                    n_state = mrw_pkg::S_DONE;
                end else begin
                    n_state = mrw_pkg::S_SQ_GO;
                end
            end
            mrw_pkg::S_DONE: begin
                if (out_free) n_state = mrw_pkg::S_IDLE;
            end
            default: n_state = mrw_pkg::S_IDLE;
        endcase
    end

    // outputs: handshake and multiplier operand select
    always_comb begin
        o_in_ready = (r_state == mrw_pkg::S_IDLE);
        mm_start   = 1'b0;
        mm_x       = r_res;
        mm_y       = r_res;
        unique case (r_state)
            mrw_pkg::S_RED_GO: begin
                mm_start = 1'b1;
                mm_x     = WIDTH'(1);
                mm_y     = r_a;
            end
            mrw_pkg::S_POWR_GO: begin
                mm_start = 1'b1;
                mm_x     = r_res;
                mm_y     = r_sq;
            end
            mrw_pkg::S_POWS_GO: begin
                mm_start = 1'b1;
                mm_x     = r_sq;
                mm_y     = r_sq;
            end
            mrw_pkg::S_SQ_GO: begin
                mm_start = 1'b1;
            end
            default: begin
                mm_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mrw_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_all_passed <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == mrw_pkg::S_DONE && out_free) begin
                r_out_valid  <= 1'b1;
                r_all_passed <= r_last ? 1'b1 : verdict;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mrw_pkg::S_IDLE: begin
                if (accept) begin
                    r_n    <= cand;
                    r_a    <= i_in_data.witness[WIDTH-1:0];
                    r_last <= i_in_data.last_witness;
                    r_nm1  <= cand - WIDTH'(1);
                    r_s    <= cand - WIDTH'(1);
                    r_r    <= '0;
                    r_res  <= WIDTH'(1);
                    r_pass <= is_two;
                end
            end
            // strip trailing zeros of n-1: s odd, r counts them
            mrw_pkg::S_SPLIT: begin
                if (!r_s[0]) begin
                    r_s <= r_s >> 1;
                    r_r <= r_r + RW'(1);
                end
            end
            mrw_pkg::S_RED_WT: begin
                if (mm_done) r_sq <= mm_prod;
            end
            mrw_pkg::S_POWR_WT: begin
                if (mm_done) r_res <= mm_prod;
            end
            mrw_pkg::S_POWS_WT: begin
                if (mm_done) begin
                    r_sq <= mm_prod;
                    r_s  <= r_s >> 1;
                end
            end
            mrw_pkg::S_TEST: begin
                r_pass <= res_is_one || res_is_nm1;
                r_r    <= r_r - RW'(1);
            end
            mrw_pkg::S_SQ_WT: begin
                if (mm_done) r_res <= mm_prod;
            end
            mrw_pkg::S_SQ_CHK: begin
                r_pass <= res_is_nm1;
                r_r    <= r_r - RW'(1);
            end
            mrw_pkg::S_DONE: begin
                if (out_free) begin
                    r_out_data.verdict   <= verdict;
                    r_out_data.final_res <= r_last;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hdl/mrw_modmul.sv =====
// ----------------------------------------------------------------------------
// mrw_modmul
// Interleaved shift-add modular multiplier, one multiplier bit per cycle,
// MSB first. Returns (x * y) mod n for any y, given x < n.
// ----------------------------------------------------------------------------
module mrw_modmul #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic [WIDTH-1:0] i_n,
    output logic             o_done,
    output logic [WIDTH-1:0] o_prod
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;

    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] mod1;
    logic [WIDTH+1:0] mod2;
    logic [WIDTH-1:0] n_acc;

    // 2*acc + x stays below 3n, so at most one of n or 2n comes off
    always_comb begin
        mod1 = {2'b00, i_n};
        mod2 = {1'b0, i_n, 1'b0};
        sum  = {1'b0, r_acc, 1'b0} + (r_y[WIDTH-1] ? {2'b00, r_x} : '0);
        if (sum >= mod2) begin
            n_acc = WIDTH'(sum - mod2);
        end else if (sum >= mod1) begin
            n_acc = WIDTH'(sum - mod1);
        end else begin
            n_acc = WIDTH'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[WIDTH-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== hdl/mrw_checker.sv =====
// ----------------------------------------------------------------------------
// mrw_checker
// Port-level checks for miller_rabin_witness_test, bound to the top level.
// ----------------------------------------------------------------------------
module mrw_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input mrw_pkg::t_in_word  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input mrw_pkg::t_out_word o_out_data
);

    logic r_open_fail;

    // a composite verdict inside a group that has not closed yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_fail <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_open_fail <= !o_out_data.final_res && !o_out_data.verdict;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after accepting a word");

    a_sticky_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_open_fail |-> !o_out_data.verdict)
        else $error("group passed after an earlier composite verdict");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("bad state after reset");

endmodule

bind miller_rabin_witness_test mrw_checker u_mrw_checker (.*);
